>>> hdl/dfb_pkg.sv
// dfb_pkg: shared types, codes and helpers for the draw filter batcher.
// No dependencies; imported by dfb_cell and draw_filter_batcher.
`default_nettype none
package dfb_pkg;

  localparam int unsigned DFB_MAX_OBJECTS = 64;
  localparam int unsigned SLOT_OUT_W      = 6;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_DRAW   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_BATCH = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;
  localparam logic [1:0] KIND_ACK   = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_OBJ  = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd2;
  localparam logic [2:0] ERR_RESOURCE = 3'd3;
  localparam logic [2:0] ERR_MISMATCH = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW = 3'd5;

  localparam logic [1:0] CFG_PHASE_EN     = 2'd0;
  localparam logic [1:0] CFG_PHASE_WANTED = 2'd1;
  localparam logic [1:0] CFG_LAYERS       = 2'd2;
  localparam logic [1:0] CFG_SHADOW_ONLY  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  // scan token handed cell to cell
  typedef struct packed {
    logic        hit;
    logic [31:0] mesh;
    logic [31:0] layers;
    logic        shadow;
    logic        free_found;
  } tok_t;

  // table write broadcast to all cells
  typedef struct packed {
    logic        en;
    logic [63:0] id;
    logic [31:0] mesh;
    logic [31:0] layers;
    logic        shadow;
  } wr_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [31:0] draw_idx;
    logic [5:0]  object_slot;
    logic [31:0] batch_mesh;
    logic [31:0] batch_material;
    logic [3:0]  batch_phase;
    logic [31:0] batch_first;
    logic [31:0] batch_count;
    logic        last;
  } res_t;

  function automatic res_t mk_simple(input logic [1:0] kind, input logic [2:0] code);
    res_t r;
    r            = '0;
    r.kind       = kind;
    r.error_code = code;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/dfb_cell.sv
// dfb_cell: one object table entry and one stage of the lookup chain.
// Depends on dfb_pkg; instantiated in a row by draw_filter_batcher.
`default_nettype none
module dfb_cell
  import dfb_pkg::*;
#(
  parameter int unsigned SLOT_W = 6,
  parameter int unsigned IDX    = 0
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               clr,
  input  wire  wr_t         wr_i,
  input  wire  [SLOT_W-1:0] wr_slot_i,
  input  wire  [63:0]       q_id_i,
  input  wire               tok_vld_i,
  input  wire  tok_t        tok_i,
  input  wire  [SLOT_W-1:0] hit_slot_i,
  input  wire  [SLOT_W-1:0] free_slot_i,
  output logic              tok_vld_o,
  output tok_t              tok_o,
  output logic [SLOT_W-1:0] hit_slot_o,
  output logic [SLOT_W-1:0] free_slot_o
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic              valid_r;
  logic [63:0]       id_r;
  logic [31:0]       mesh_r;
  logic [31:0]       layers_r;
  logic              shadow_r;
  logic              match;
  logic              wr_me;
  tok_t              tok_nxt;
  logic [SLOT_W-1:0] hit_slot_nxt;
  logic [SLOT_W-1:0] free_slot_nxt;

  assign match = valid_r && (id_r == q_id_i);
  assign wr_me = wr_i.en && (wr_slot_i == MY_SLOT);

  always_comb begin
    tok_nxt       = tok_i;
    hit_slot_nxt  = hit_slot_i;
    free_slot_nxt = free_slot_i;
    if (!tok_i.hit && match) begin
      tok_nxt.hit    = 1'b1;
      tok_nxt.mesh   = mesh_r;
      tok_nxt.layers = layers_r;
      tok_nxt.shadow = shadow_r;
      hit_slot_nxt   = MY_SLOT;
    end
    if (!tok_i.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      free_slot_nxt      = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= 1'b0;
    end else if (wr_me) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_me) begin
      id_r     <= wr_i.id;
      mesh_r   <= wr_i.mesh;
      layers_r <= wr_i.layers;
      shadow_r <= wr_i.shadow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_o <= 1'b0;
    end else begin
      tok_vld_o <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    tok_o       <= tok_nxt;
    hit_slot_o  <= hit_slot_nxt;
    free_slot_o <= free_slot_nxt;
  end

endmodule
`default_nettype wire

>>> hdl/draw_filter_batcher.sv
// draw_filter_batcher: object table, draw filter and batch builder (top level).
// Depends on dfb_pkg and dfb_cell.
//
// Usage: commands arrive on the in_ channel (valid/stall); results leave on
// the out_ channel (valid/stall), one to two per command, the final one
// flagged by out_last. Registers are to be written by the user through the
// cfg_ port only while idle; the block does not enforce it. Unless the error
// flag is set, load and draw commands send a lookup token down a row of
// MAX_OBJECTS table cells, one cell per cycle, and answer when it leaves the
// last one. Finish and clear answer in the cycle after acceptance. One
// command is in flight at a time: in_stall stays high from acceptance until
// its last result is transferred. While out_stall is high the result holds.
// Reset empties the table, closes the batch, clears the error flag and loads
// the register defaults (filter_layers all ones, others zero); while rst_n is
// low in_stall is high and cfg_ready is low.
`default_nettype none
module draw_filter_batcher
  import dfb_pkg::*;
#(
  parameter int unsigned MAX_OBJECTS = DFB_MAX_OBJECTS
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_cmd,
  input  wire  [63:0] in_object_id,
  input  wire  [31:0] in_mesh_id,
  input  wire  [31:0] in_material_id,
  input  wire  [3:0]  in_draw_phase,
  input  wire  [31:0] in_object_layers,
  input  wire         in_casts_shadow,
  input  wire  [31:0] in_index_count,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_draw_idx,
  output logic [5:0]  out_object_slot,
  output logic [31:0] out_batch_mesh,
  output logic [31:0] out_batch_material,
  output logic [3:0]  out_batch_phase,
  output logic [31:0] out_batch_first,
  output logic [31:0] out_batch_count,
  output logic        out_last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  localparam int unsigned SLOT_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

  // configuration
  logic        pf_en_r;
  logic [3:0]  phase_wanted_r;
  logic [31:0] filter_layers_r;
  logic        shadow_only_r;

  // latched command
  logic [1:0]  q_cmd_r;
  logic [63:0] q_id_r;
  logic [31:0] q_mesh_r;
  logic [31:0] q_mat_r;
  logic [3:0]  q_phase_r;
  logic [31:0] q_layers_r;
  logic        q_shadow_r;
  logic [31:0] q_icount_r;

  state_t      state_r, state_nxt;
  logic        start_r, start_nxt;
  logic        failed_r, failed_nxt;
  logic [31:0] kept_r, kept_nxt;
  logic        bopen_r, bopen_nxt;
  logic [31:0] open_mesh_r, open_mesh_nxt;
  logic [31:0] open_mat_r, open_mat_nxt;
  logic [3:0]  open_phase_r, open_phase_nxt;
  logic [31:0] open_first_r, open_first_nxt;
  logic [31:0] open_count_r, open_count_nxt;
  res_t        head_r, head_nxt;
  res_t        tail_r, tail_nxt;
  logic        tail_vld_r, tail_vld_nxt;

  logic        in_xfer;
  logic        out_xfer;
  logic        clr;
  wr_t         wr;
  logic [SLOT_W-1:0] wr_slot;

  logic              tok_vld   [MAX_OBJECTS+1];
  tok_t              tok       [MAX_OBJECTS+1];
  logic [SLOT_W-1:0] hit_slot  [MAX_OBJECTS+1];
  logic [SLOT_W-1:0] free_slot [MAX_OBJECTS+1];

  tok_t        tok_end;
  logic        tok_end_vld;
  logic        filtered;
  logic        fits;
  res_t        batch_res;
  res_t        draw_res;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign out_xfer  = out_valid && !out_stall;
  assign cfg_ready = rst_n;

  assign out_kind           = head_r.kind;
  assign out_error_code     = head_r.error_code;
  assign out_draw_idx       = head_r.draw_idx;
  assign out_object_slot    = head_r.object_slot;
  assign out_batch_mesh     = head_r.batch_mesh;
  assign out_batch_material = head_r.batch_material;
  assign out_batch_phase    = head_r.batch_phase;
  assign out_batch_first    = head_r.batch_first;
  assign out_batch_count    = head_r.batch_count;
  assign out_last           = head_r.last;

  // lookup chain
  assign tok_vld[0]   = start_r;
  assign tok[0]       = '0;
  assign hit_slot[0]  = '0;
  assign free_slot[0] = '0;

  for (genvar g = 0; g < MAX_OBJECTS; g++) begin : g_cell
    dfb_cell #(
      .SLOT_W (SLOT_W),
      .IDX    (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .clr         (clr),
      .wr_i        (wr),
      .wr_slot_i   (wr_slot),
      .q_id_i      (q_id_r),
      .tok_vld_i   (tok_vld[g]),
      .tok_i       (tok[g]),
      .hit_slot_i  (hit_slot[g]),
      .free_slot_i (free_slot[g]),
      .tok_vld_o   (tok_vld[g+1]),
      .tok_o       (tok[g+1]),
      .hit_slot_o  (hit_slot[g+1]),
      .free_slot_o (free_slot[g+1])
    );
  end

  assign tok_end     = tok[MAX_OBJECTS];
  assign tok_end_vld = tok_vld[MAX_OBJECTS];

  assign filtered = (pf_en_r && (q_phase_r != phase_wanted_r)) ||
                    ((tok_end.layers & filter_layers_r) == 32'd0) ||
                    (shadow_only_r && !tok_end.shadow);
  assign fits     = bopen_r && (open_mesh_r == q_mesh_r) && (open_mat_r == q_mat_r) &&
                    (open_phase_r == q_phase_r);

  always_comb begin
    batch_res                = '0;
    batch_res.kind           = KIND_BATCH;
    batch_res.batch_mesh     = open_mesh_r;
    batch_res.batch_material = open_mat_r;
    batch_res.batch_phase    = open_phase_r;
    batch_res.batch_first    = open_first_r;
    batch_res.batch_count    = open_count_r;
    draw_res                 = '0;
    draw_res.kind            = KIND_DRAW;
    draw_res.draw_idx        = kept_r;
    draw_res.object_slot     = SLOT_OUT_W'(hit_slot[MAX_OBJECTS]);
    draw_res.last            = 1'b1;
  end

  always_comb begin
    state_nxt      = state_r;
    start_nxt      = 1'b0;
    failed_nxt     = failed_r;
    kept_nxt       = kept_r;
    bopen_nxt      = bopen_r;
    open_mesh_nxt  = open_mesh_r;
    open_mat_nxt   = open_mat_r;
    open_phase_nxt = open_phase_r;
    open_first_nxt = open_first_r;
    open_count_nxt = open_count_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    tail_vld_nxt   = tail_vld_r;
    clr            = 1'b0;
    wr.en          = 1'b0;
    wr.id          = q_id_r;
    wr.mesh        = q_mesh_r;
    wr.layers      = q_layers_r;
    wr.shadow      = q_shadow_r;
    wr_slot        = free_slot[MAX_OBJECTS];
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          tail_vld_nxt = 1'b0;
          if (in_cmd == CMD_CLEAR) begin
            clr            = 1'b1;
            failed_nxt     = 1'b0;
            kept_nxt       = '0;
            bopen_nxt      = 1'b0;
            open_mesh_nxt  = '0;
            open_mat_nxt   = '0;
            open_phase_nxt = '0;
            open_first_nxt = '0;
            open_count_nxt = '0;
            head_nxt       = mk_simple(KIND_ACK, ERR_NONE);
            state_nxt      = S_OUT;
          end else if (failed_r) begin
            head_nxt  = mk_simple(KIND_ACK, ERR_NONE);
            state_nxt = S_OUT;
          end else if (in_cmd == CMD_FINISH) begin
            if (bopen_r) begin
              head_nxt      = batch_res;
              head_nxt.last = 1'b1;
            end else begin
              head_nxt = mk_simple(KIND_ACK, ERR_NONE);
            end
            bopen_nxt      = 1'b0;
            open_count_nxt = '0;
            kept_nxt       = '0;
            state_nxt      = S_OUT;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tok_end_vld) begin
          state_nxt = S_OUT;
          if (q_cmd_r == CMD_LOAD) begin
            if (q_id_r == 64'd0 || tok_end.hit) begin
              failed_nxt = 1'b1;
              head_nxt   = mk_simple(KIND_ERR, ERR_BAD_OBJ);
            end else if (!tok_end.free_found) begin
              failed_nxt = 1'b1;
              head_nxt   = mk_simple(KIND_ERR, ERR_OVERFLOW);
            end else begin
              wr.en    = 1'b1;
              head_nxt = mk_simple(KIND_ACK, ERR_NONE);
            end
          end else if (q_id_r == 64'd0 || !tok_end.hit) begin
            failed_nxt = 1'b1;
            head_nxt   = mk_simple(KIND_ERR, ERR_UNKNOWN);
          end else if (q_mesh_r == 32'd0 || q_mat_r == 32'd0 || q_icount_r == 32'd0) begin
            failed_nxt = 1'b1;
            head_nxt   = mk_simple(KIND_ERR, ERR_RESOURCE);
          end else if (q_mesh_r != tok_end.mesh) begin
            failed_nxt = 1'b1;
            head_nxt   = mk_simple(KIND_ERR, ERR_MISMATCH);
          end else if (filtered) begin
            head_nxt = mk_simple(KIND_ACK, ERR_NONE);
          end else if (kept_r == 32'hFFFF_FFFF) begin
            failed_nxt = 1'b1;
            head_nxt   = mk_simple(KIND_ERR, ERR_OVERFLOW);
          end else begin
            kept_nxt = kept_r + 32'd1;
            if (fits) begin
              open_count_nxt = open_count_r + 32'd1;
              head_nxt       = draw_res;
            end else begin
              if (bopen_r) begin
                head_nxt     = batch_res;
                tail_nxt     = draw_res;
                tail_vld_nxt = 1'b1;
              end else begin
                head_nxt = draw_res;
              end
              bopen_nxt      = 1'b1;
              open_mesh_nxt  = q_mesh_r;
              open_mat_nxt   = q_mat_r;
              open_phase_nxt = q_phase_r;
              open_first_nxt = kept_r;
              open_count_nxt = 32'd1;
            end
          end
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          if (tail_vld_r) begin
            head_nxt     = tail_r;
            tail_vld_nxt = 1'b0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_r      <= 1'b0;
      failed_r     <= 1'b0;
      kept_r       <= '0;
      bopen_r      <= 1'b0;
      open_mesh_r  <= '0;
      open_mat_r   <= '0;
      open_phase_r <= '0;
      open_first_r <= '0;
      open_count_r <= '0;
      tail_vld_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_r      <= start_nxt;
      failed_r     <= failed_nxt;
      kept_r       <= kept_nxt;
      bopen_r      <= bopen_nxt;
      open_mesh_r  <= open_mesh_nxt;
      open_mat_r   <= open_mat_nxt;
      open_phase_r <= open_phase_nxt;
      open_first_r <= open_first_nxt;
      open_count_r <= open_count_nxt;
      tail_vld_r   <= tail_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    if (in_xfer) begin
      q_cmd_r    <= in_cmd;
      q_id_r     <= in_object_id;
      q_mesh_r   <= in_mesh_id;
      q_mat_r    <= in_material_id;
      q_phase_r  <= in_draw_phase;
      q_layers_r <= in_object_layers;
      q_shadow_r <= in_casts_shadow;
      q_icount_r <= in_index_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_en_r         <= 1'b0;
      phase_wanted_r  <= 4'd0;
      filter_layers_r <= 32'hFFFF_FFFF;
      shadow_only_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_EN:     pf_en_r         <= cfg_data[0];
        CFG_PHASE_WANTED: phase_wanted_r  <= cfg_data[3:0];
        CFG_LAYERS:       filter_layers_r <= cfg_data;
        CFG_SHADOW_ONLY:  shadow_only_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // checks
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_tail_after_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_vld_r && state_r == S_OUT) |-> (head_r.kind == KIND_BATCH && !head_r.last))
    else $error("second result queued behind a non-batch result");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end_vld |-> (state_r == S_SCAN))
    else $error("lookup token arrived outside a scan");

  a_fail_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(failed_r) |-> (head_r.kind == KIND_ERR && state_r == S_OUT))
    else $error("error flag set without an error result");

endmodule
`default_nettype wire
